>>> rtl/bsa_pkg.sv
// shared types, codes and helpers for the bitmap slot allocator
package bsa_pkg;

    // fixed word size of the bitmap store
    localparam int WORD_BITS = 32;
    localparam int BIT_SEL_W = 5;

    // request kinds
    typedef enum logic [2:0] {
        KIND_SET   = 3'd0,
        KIND_CLEAR = 3'd1,
        KIND_TEST  = 3'd2,
        KIND_FFC   = 3'd3,
        KIND_FFS   = 3'd4,
        KIND_ALLOC = 3'd5
    } t_kind;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NONE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BITOP,
        S_SCAN
    } t_state;

    // request payload
    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] bit_index;
    } t_bsa_req;

    // result payload
    typedef struct packed {
        t_status     status;
        logic [11:0] position;
        logic        bit_value;
    } t_bsa_res;

    // index of the lowest one bit of a word, zero when the word is empty
    function automatic logic [BIT_SEL_W-1:0] lowest_one(input logic [WORD_BITS-1:0] w);
        logic [BIT_SEL_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                r = BIT_SEL_W'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/bitmap_slot_allocator_unit.sv
// top level of the bitmap slot allocator: request control, word scan and result register
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+------------------------
//  request   | in        | start / busy (taken: !busy)   | i_req (kind, bit_index)
//  result    | out       | o_done strobe, one cycle      | o_result
//  config    | in        | i_cfg_valid / o_cfg_ready     | i_cfg_data (active_bits)
//
// set, clear and test read one word; set and clear then modify it and write it back.
// searches scan the words in turn from word zero, up to NUM_WORDS (128 at 4096 bits):
// the scan reads one word per cycle through the single read port of the store.
// out of range indexes and unknown kinds answer in the cycle after they are taken, without touching the store.
// after reset a clearing pass writes zeros to all NUM_WORDS words, busy stays high.
// results cannot be stalled; each is shown for exactly one cycle after its request ends.
module bitmap_slot_allocator_unit
    import bsa_pkg::*;
#(
    parameter int NUM_BITS = 4096
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_bsa_req i_req,
    output logic     o_done,
    output t_bsa_res o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);

    localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BASE_W    = WORD_AW + BIT_SEL_W;
    localparam int CMP_W     = ((BASE_W > 13) ? BASE_W : 13) + 1;
    localparam int CAP       = (NUM_BITS < 8191) ? NUM_BITS : 8191;

    t_state                 r_state, n_state;
    logic [WORD_AW-1:0]     r_ptr, n_ptr;
    logic [2:0]             r_kind;
    logic [11:0]            r_idx;
    logic [12:0]            r_active;
    logic                   r_done, n_done;
    t_bsa_res               r_result, n_result;

    logic                   rd_en, wr_en;
    logic [WORD_AW-1:0]     rd_addr, wr_addr;
    logic [WORD_BITS-1:0]   rd_data, wr_data;

    logic                   w_accept;
    logic [12:0]            w_limit;
    logic                   w_in_range;
    logic [WORD_BITS-1:0]   w_mask;
    logic                   w_bitval;
    logic [WORD_BITS-1:0]   w_look;
    logic [BIT_SEL_W-1:0]   w_bit;
    logic [CMP_W-1:0]       w_base, w_pos, w_lim_x;
    logic                   w_past_lim, w_hit, w_last, w_finish, w_found;

    // word store
    bsa_ram #(
        .DEPTH (NUM_WORDS),
        .AW    (WORD_AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // handshakes
    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;

    // active count saturated to the bitmap size
    assign w_limit    = (r_active > 13'(CAP)) ? 13'(CAP) : r_active;
    assign w_in_range = 13'(i_req.bit_index) < w_limit;

    // single bit access
    assign w_mask   = WORD_BITS'(1) << r_idx[BIT_SEL_W-1:0];
    assign w_bitval = |(rd_data & w_mask);

    // scan of the current word
    assign w_look     = (r_kind == KIND_FFS) ? rd_data : ~rd_data;
    assign w_bit      = lowest_one(w_look);
    assign w_base     = CMP_W'({r_ptr, {BIT_SEL_W{1'b0}}});
    assign w_pos      = w_base + CMP_W'(w_bit);
    assign w_lim_x    = CMP_W'(w_limit);
    assign w_past_lim = (w_base >= w_lim_x);
    assign w_hit      = (w_look != '0);
    assign w_last     = (r_ptr == WORD_AW'(NUM_WORDS - 1));
    assign w_finish   = w_past_lim || w_hit || w_last;
    assign w_found    = !w_past_lim && w_hit && (w_pos < w_lim_x);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.kind)
                        KIND_SET, KIND_CLEAR, KIND_TEST: begin
                            if (w_in_range) begin
                                n_state = S_BITOP;
                            end
                        end
                        KIND_FFC, KIND_FFS, KIND_ALLOC: n_state = S_SCAN;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_BITOP: n_state = S_IDLE;
            S_SCAN: begin
                if (w_finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // store accesses, scan pointer and result
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = r_ptr;
        wr_data  = '0;
        n_ptr    = r_ptr;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
                n_ptr = r_ptr + 1'b1;
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_req.kind)
                        KIND_SET, KIND_CLEAR, KIND_TEST: begin
                            if (w_in_range) begin
                                rd_en   = 1'b1;
                                rd_addr = WORD_AW'(i_req.bit_index[11:BIT_SEL_W]);
                            end else begin
                                n_done   = 1'b1;
                                n_result = '{ST_RANGE, i_req.bit_index, 1'b0};
                            end
                        end
                        KIND_FFC, KIND_FFS, KIND_ALLOC: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_ptr   = '0;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '{ST_RANGE, i_req.bit_index, 1'b0};
                        end
                    endcase
                end
            end
            S_BITOP: begin
                wr_addr  = WORD_AW'(r_idx[11:BIT_SEL_W]);
                n_done   = 1'b1;
                n_result = '{ST_OK, r_idx, w_bitval};
                case (r_kind)
                    KIND_SET: begin
                        wr_en   = 1'b1;
                        wr_data = rd_data | w_mask;
                    end
                    KIND_CLEAR: begin
                        wr_en   = 1'b1;
                        wr_data = rd_data & ~w_mask;
                    end
                    default: wr_en = 1'b0;
                endcase
            end
            S_SCAN: begin
                if (w_finish) begin
                    n_done = 1'b1;
                    if (w_found) begin
                        n_result = '{ST_OK, 12'(w_pos), (r_kind == KIND_FFS)};
                        if (r_kind == KIND_ALLOC) begin
                            wr_en   = 1'b1;
                            wr_data = rd_data | (WORD_BITS'(1) << w_bit);
                        end
                    end else begin
                        n_result = '{ST_NONE, 12'd0, 1'b0};
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr + 1'b1;
                    n_ptr   = r_ptr + 1'b1;
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ptr    <= '0;
            r_done   <= 1'b0;
            r_active <= 13'd4096;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_req.kind;
            r_idx  <= i_req.bit_index;
        end
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // a result follows a request that ended in the previous cycle
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(w_accept) || $past(r_state) == S_BITOP
                    || $past(r_state) == S_SCAN))
        else $error("result strobe without a finishing request");

    // nothing found reports position zero and a clear bit value
    a_none_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_NONE) |->
            (o_result.position == 12'd0 && !o_result.bit_value))
        else $error("empty search result carries stale fields");

    // the store is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state != S_IDLE))
        else $error("store write while idle");

    // no result during the clearing pass
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_done)
        else $error("result during clearing pass");

    // a successful clear search reports a clear bit
    a_ffc_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_kind == KIND_FFC && o_result.status == ST_OK) |->
            !o_result.bit_value)
        else $error("clear search reported a set bit");

endmodule

>>> rtl/bsa_ram.sv
// single-port-write, single-port-read word store with registered read data
module bsa_ram
    import bsa_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port with registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
